@@ rtl/core/tbpf_pkg.sv @@
// Shared types and constants for the text background pixel fetch core.
// No dependencies; imported by tbpf_snap and the top level.
package tbpf_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_BLOCK = 3'd0,
        CFG_CHAR_BLOCK   = 3'd1,
        CFG_SCROLL_X     = 3'd2,
        CFG_SCROLL_Y     = 3'd3,
        CFG_MAP_SIZE     = 3'd4,
        CFG_COLOR_MODE   = 3'd5,
        CFG_MOSAIC_H     = 3'd6,
        CFG_MOSAIC_V     = 3'd7
    } t_cfg_reg;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SNAP_X,
        ST_SNAP_Y,
        ST_MAP_CALC,
        ST_MAP_WRAP_HI,
        ST_MAP_WRAP_LO,
        ST_MAP_READ,
        ST_TEX_CALC,
        ST_TEX_WRAP_HI,
        ST_TEX_WRAP_LO,
        ST_TEX_READ,
        ST_RESULT
    } t_state;

    // request into the shared mosaic divider
    typedef struct packed {
        logic       start;
        logic [7:0] value;
        logic [4:0] div;
    } t_snap_req;

    // response: value snapped down to a multiple of div
    typedef struct packed {
        logic       done;
        logic [7:0] result;
    } t_snap_rsp;

endpackage

@@ rtl/core/text_background_pixel_fetch_core.sv @@
// Scrolled tile-map background layer: video memory, mosaic, scroll, map and texel fetch.
// Uses tbpf_pkg, tbpf_snap and tbpf_vram.
//
// A write item (tuser 0) stores one halfword and the core is ready again the next cycle.
// A fetch item (tuser 1) occupies the core from acceptance to the next acceptance: two
// mosaic divisions of eight steps each plus the handoff through one shared subtractor,
// then an address calculation, two address wraps and a read on the single memory port for
// the map entry, the same calculation, wraps and read for the tile texel, loading the
// result and a return to idle to take the next item. A finished result sits in the output
// register while the next item is accepted; if that register still holds an unaccepted
// result when a fetch completes, the core waits until the output is taken.
// Video memory has no reset; only locations already written may be read.
module text_background_pixel_fetch_core #(
    parameter int VRAM_HALFWORDS = 32768
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config write port
    input  logic                                i_cfg_we,
    input  logic [tbpf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tbpf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input items
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [14:0] mem_address, [30:15] mem_data, [38:31] pixel_x, [46:39] line, [47] zero
    input  logic [47:0]                         s_axis_tdata,
    // [0] command
    input  logic                                s_axis_tuser,
    // result items
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] color_index
    output logic [7:0]                          m_axis_tdata,
    // [0] transparent
    output logic                                m_axis_tuser
);
    import tbpf_pkg::*;

    localparam int          AW     = $clog2(VRAM_HALFWORDS);
    localparam logic [16:0] DEPTH1 = 17'(VRAM_HALFWORDS);
    localparam logic [16:0] DEPTH2 = 17'(2 * VRAM_HALFWORDS);

    // config registers
    logic [4:0] r_screen_block;
    logic [1:0] r_char_block;
    logic [8:0] r_scroll_x;
    logic [8:0] r_scroll_y;
    logic [1:0] r_map_size;
    logic       r_color_mode;
    logic [4:0] r_mosaic_h;
    logic [4:0] r_mosaic_v;

    t_state     r_state;
    t_state     n_state;
    logic [7:0] r_px;
    logic [7:0] r_ln;
    logic [15:0] r_addr;
    logic [15:0] r_entry;
    logic       r_bsel;
    logic       r_col0;
    logic       r_m_valid;
    logic [7:0] r_color;
    logic       r_transp;

    t_snap_req  w_snap_req;
    t_snap_rsp  w_snap_rsp;
    logic       w_in_acc;
    logic       w_mem_we;
    logic       w_mem_re;
    logic [AW-1:0] w_mem_addr;
    logic [15:0] w_rdata;
    logic       w_out_free;

    logic [14:0] w_wr_addr;
    logic [15:0] w_wr_wrap;
    logic [9:0]  w_x1;
    logic [9:0]  w_y1;
    logic        w_wide;
    logic        w_tx_hi;
    logic        w_ty_hi;
    logic [15:0] w_map_addr;
    logic [2:0]  w_col;
    logic [2:0]  w_row;
    logic [15:0] w_off;
    logic [16:0] w_byte_addr;
    logic [16:0] w_addr17;
    logic [7:0]  w_byte;
    logic [3:0]  w_nib;
    logic [7:0]  w_value;

    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_m_valid || m_axis_tready;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_block <= '0;
            r_char_block   <= '0;
            r_scroll_x     <= '0;
            r_scroll_y     <= '0;
            r_map_size     <= '0;
            r_color_mode   <= 1'b1;
            r_mosaic_h     <= '0;
            r_mosaic_v     <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_SCREEN_BLOCK: r_screen_block <= i_cfg_data[4:0];
                CFG_CHAR_BLOCK:   r_char_block   <= i_cfg_data[1:0];
                CFG_SCROLL_X:     r_scroll_x     <= i_cfg_data[8:0];
                CFG_SCROLL_Y:     r_scroll_y     <= i_cfg_data[8:0];
                CFG_MAP_SIZE:     r_map_size     <= i_cfg_data[1:0];
                CFG_COLOR_MODE:   r_color_mode   <= i_cfg_data[0];
                CFG_MOSAIC_H:     r_mosaic_h     <= i_cfg_data[4:0];
                CFG_MOSAIC_V:     r_mosaic_v     <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // address arithmetic
    assign w_wr_addr = s_axis_tdata[14:0];
    assign w_wr_wrap = ({2'b00, w_wr_addr} >= DEPTH1) ? 16'({2'b00, w_wr_addr} - DEPTH1)
                                                      : {1'b0, w_wr_addr};

    assign w_x1    = {2'b00, r_px} + {1'b0, r_scroll_x};
    assign w_y1    = {2'b00, r_ln} + {1'b0, r_scroll_y};
    assign w_wide  = r_map_size[0];
    assign w_tx_hi = w_wide & w_x1[8];
    assign w_ty_hi = r_map_size[1] & w_y1[8];

    assign w_map_addr = {1'b0, r_screen_block, 10'b0}
                      + {4'b0, (w_ty_hi & w_wide), 11'b0}
                      + {5'b0, (w_ty_hi & ~w_wide), w_y1[7:3], 5'b0}
                      + {5'b0, (w_tx_hi & w_wide), 10'b0}
                      + {11'b0, w_x1[7:3]};

    assign w_col       = w_x1[2:0] ^ {3{w_rdata[10]}};
    assign w_row       = w_y1[2:0] ^ {3{w_rdata[11]}};
    assign w_off       = {w_rdata[9:0], w_row, w_col};
    assign w_byte_addr = {1'b0, r_char_block, 14'b0}
                       + (r_color_mode ? {2'b00, w_off[15:1]} : {1'b0, w_off});

    assign w_addr17 = {1'b0, r_addr};

    assign w_byte  = r_bsel ? w_rdata[15:8] : w_rdata[7:0];
    assign w_nib   = r_col0 ? w_byte[7:4] : w_byte[3:0];
    assign w_value = !r_color_mode ? w_byte
                   : (w_nib != 4'd0) ? {r_entry[15:12], w_nib} : 8'd0;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && s_axis_tuser == CMD_FETCH) n_state = ST_SNAP_X;
            end
            ST_SNAP_X:      if (w_snap_rsp.done) n_state = ST_SNAP_Y;
            ST_SNAP_Y:      if (w_snap_rsp.done) n_state = ST_MAP_CALC;
            ST_MAP_CALC:    n_state = ST_MAP_WRAP_HI;
            ST_MAP_WRAP_HI: n_state = ST_MAP_WRAP_LO;
            ST_MAP_WRAP_LO: n_state = ST_MAP_READ;
            ST_MAP_READ:    n_state = ST_TEX_CALC;
            ST_TEX_CALC:    n_state = ST_TEX_WRAP_HI;
            ST_TEX_WRAP_HI: n_state = ST_TEX_WRAP_LO;
            ST_TEX_WRAP_LO: n_state = ST_TEX_READ;
            ST_TEX_READ:    n_state = ST_RESULT;
            ST_RESULT:      if (w_out_free) n_state = ST_IDLE;
            default:        n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready    = 1'b0;
        w_mem_we         = 1'b0;
        w_mem_re         = 1'b0;
        w_mem_addr       = r_addr[AW-1:0];
        w_snap_req.start = 1'b0;
        w_snap_req.value = r_ln;
        w_snap_req.div   = r_mosaic_v;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready    = 1'b1;
                w_mem_we         = w_in_acc && s_axis_tuser == CMD_WRITE;
                w_mem_addr       = w_wr_wrap[AW-1:0];
                w_snap_req.start = w_in_acc && s_axis_tuser == CMD_FETCH;
                w_snap_req.value = s_axis_tdata[38:31];
                w_snap_req.div   = r_mosaic_h;
            end
            ST_SNAP_X:   w_snap_req.start = w_snap_rsp.done;
            ST_MAP_READ: w_mem_re = 1'b1;
            ST_TEX_READ: w_mem_re = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_RESULT && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_ln <= s_axis_tdata[46:39];
            end
            ST_SNAP_X: if (w_snap_rsp.done) r_px <= w_snap_rsp.result;
            ST_SNAP_Y: if (w_snap_rsp.done) r_ln <= w_snap_rsp.result;
            ST_MAP_CALC: r_addr <= w_map_addr;
            ST_MAP_WRAP_HI, ST_TEX_WRAP_HI: begin
                if (w_addr17 >= DEPTH2) r_addr <= 16'(w_addr17 - DEPTH2);
            end
            ST_MAP_WRAP_LO, ST_TEX_WRAP_LO: begin
                if (w_addr17 >= DEPTH1) r_addr <= 16'(w_addr17 - DEPTH1);
            end
            ST_TEX_CALC: begin
                r_entry <= w_rdata;
                r_addr  <= w_byte_addr[16:1];
                r_bsel  <= w_byte_addr[0];
                r_col0  <= w_col[0];
            end
            ST_RESULT: begin
                if (w_out_free) begin
                    r_color  <= w_value;
                    r_transp <= (w_value == 8'd0);
                end
            end
            default: ;
        endcase
    end

    tbpf_snap u_snap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_snap_req),
        .o_rsp   (w_snap_rsp)
    );

    tbpf_vram #(
        .DEPTH (VRAM_HALFWORDS)
    ) u_vram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_re    (w_mem_re),
        .i_addr  (w_mem_addr),
        .i_wdata (s_axis_tdata[30:15]),
        .o_rdata (w_rdata)
    );

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_color;
    assign m_axis_tuser  = r_transp;

    a_snap_done_in_snap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_snap_rsp.done |-> (r_state == ST_SNAP_X || r_state == ST_SNAP_Y))
        else $error("divider finished outside a mosaic step");

    a_read_addr_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAP_READ || r_state == ST_TEX_READ) |-> (w_addr17 < DEPTH1))
        else $error("memory read address not wrapped");

    a_result_from_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state) == ST_RESULT)
        else $error("result appeared without a finished fetch");

    a_transparent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 8'd0))
        else $error("transparent pixel with nonzero color");

endmodule

@@ rtl/core/tbpf_snap.sv @@
// Shared restoring divider that snaps a coordinate down to a mosaic grid.
// One quotient bit per cycle for each 8-bit value. Uses tbpf_pkg.
module tbpf_snap (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tbpf_pkg::t_snap_req i_req,
    output tbpf_pkg::t_snap_rsp o_rsp
);
    import tbpf_pkg::*;

    logic       r_busy;
    logic [2:0] r_cnt;
    logic [7:0] r_val;
    logic [7:0] r_orig;
    logic [4:0] r_rem;
    logic [4:0] r_div;
    logic       r_done;
    logic [7:0] r_res;

    logic [5:0] w_trial;
    logic       w_ge;
    logic [4:0] n_rem;

    assign w_trial = {r_rem, r_val[7]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign n_rem   = w_ge ? 5'(w_trial - {1'b0, r_div}) : w_trial[4:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_val  <= i_req.value;
            r_orig <= i_req.value;
            r_div  <= i_req.div;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_val <= {r_val[6:0], 1'b0};
            r_rem <= n_rem;
            if (r_cnt == 3'd7) begin
                r_res <= (r_div == 5'd0) ? r_orig : r_orig - {3'b000, n_rem};
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

endmodule

@@ rtl/core/tbpf_vram.sv @@
// Single-port video memory, 16-bit halfwords, registered read data.
// No package dependency; instantiated by the top level.
module tbpf_vram #(
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [15:0]              i_wdata,
    output logic [15:0]              o_rdata
);
    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
